// File: hw/rtl/assert_macros.svh
// Assertion macros shared by the linearizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with its own message; disabled while reset is asserted.
`define GSPL_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Same check with a generic message.
`define GSPL_ASSERT(lbl, prop) `GSPL_ASSERT_MSG(lbl, prop, "linearizer assertion violated")

`endif

// File: hw/rtl/gspl_pkg.sv
// Types, constants and elaboration-time functions for the gas sensor linearizer.
package gspl_pkg;

  localparam int SAMPLE_W = 12;
  localparam int QUO_W = 24;
  localparam int LOG_STEPS = 16;
  localparam int EXP_STEPS = 16;
  localparam logic [23:0] SAT24 = 24'hFFFFFF;
  localparam logic [15:0] PPM_MAX_Q6 = 16'd64000;
  localparam logic [12:0] MV_MAX = 13'd8191;
  localparam logic [6:0] PCT_MAX = 7'd127;
  localparam int LOW_MV_LIM = 10;
  localparam int PPM_IP_MAX = 18;
  localparam longint unsigned RECIP_1000 = (64'd1 << 41) / 1000;

  typedef enum logic [1:0] {
    CFG_ADC_FULL_SCALE = 2'd0,
    CFG_SUPPLY_MV      = 2'd1,
    CFG_LOAD_OHMS      = 2'd2,
    CFG_CLEAN_AIR_OHMS = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [11:0] s;
    logic        alert;
    logic        calc;
    logic        cz;
    logic [24:0] sv;
    logic [35:0] num;
    logic [31:0] den;
    logic [12:0] mv;
    logic [6:0]  pct;
    logic [23:0] rs;
    logic [23:0] ratio;
    logic [4:0]  msb;
    logic [30:0] mant;
    logic [15:0] frac;
    logic        pz;
    logic        psat;
    logic [31:0] gp;
    logic [22:0] q0;
    logic [6:0]  ip;
    logic [15:0] ef;
    logic [30:0] ex;
    logic [15:0] ppm;
  } pipe_t;

  function automatic longint unsigned isqrt64(input longint unsigned v);
    longint unsigned r;
    longint unsigned b;
    longint unsigned x;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    x = v;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint unsigned log2_q16(input longint unsigned x);
    int unsigned msb;
    longint unsigned m;
    longint unsigned frac;
    msb = 0;
    frac = 0;
    while (msb < 29 && (x >> (msb + 1)) != 0) msb++;
    m = x << (30 - msb);
    for (int i = 0; i < 16; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac = frac | (64'd1 << (15 - i));
      end
    end
    return (64'(msb) << 16) | frac;
  endfunction

  // Root used for fraction bit k of the exponent: 2^(2^(k-16)) in Q30.
  function automatic logic [30:0] exp_root(input int k);
    longint unsigned root;
    root = 64'd2 << 30;
    for (int j = 15; j >= k; j--) root = isqrt64(root << 30);
    return root[30:0];
  endfunction

  localparam longint unsigned LOG2_10_Q16 = log2_q16(10);
  localparam longint unsigned C_Q16 = (152 * LOG2_10_Q16 + 50) / 100;

endpackage

// File: hw/rtl/gspl_ifs.sv
// Valid/ready channel interfaces for the linearizer input and result streams.
interface gspl_in_if;
  logic                          valid;
  logic                          ready;
  logic [gspl_pkg::SAMPLE_W-1:0] adc_sample;
  logic                          alert_in;

  modport source(output valid, output adc_sample, output alert_in, input ready);
  modport sink(input valid, input adc_sample, input alert_in, output ready);
endinterface

interface gspl_out_if;
  logic        valid;
  logic        ready;
  logic [12:0] voltage_mv;
  logic [6:0]  percent;
  logic [23:0] sensor_ohms;
  logic [23:0] ratio_q16;
  logic [15:0] ppm_q6;
  logic        alert_out;

  modport source(output valid, output voltage_mv, output percent, output sensor_ohms,
                 output ratio_q16, output ppm_q6, output alert_out, input ready);
  modport sink(input valid, input voltage_mv, input percent, input sensor_ohms,
               input ratio_q16, input ppm_q6, input alert_out, output ready);
endinterface

// File: hw/rtl/gspl_div.sv
// Pipelined restoring divider: overflow check, then one quotient bit per stage.
module gspl_div #(
  parameter int NUM_W = 27,
  parameter int DEN_W = 17,
  parameter int QUO_W = 24
) (
  input  logic             clk_i,
  input  logic [QUO_W:0]   en_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic [QUO_W-1:0] quo_o
);

  localparam int SH_W = DEN_W + QUO_W;
  localparam int W = (NUM_W > SH_W) ? NUM_W : SH_W;

  logic [W-1:0]     rem_q [QUO_W+1];
  logic [W-1:0]     rem_d [QUO_W+1];
  logic [DEN_W-1:0] den_q [QUO_W+1];
  logic [QUO_W-1:0] quo_q [QUO_W+1];
  logic [QUO_W-1:0] quo_d [QUO_W+1];
  logic             ovf_q [QUO_W+1];
  logic             ovf_d;

  // A quotient that needs more than QUO_W bits saturates to all ones.
  assign ovf_d = W'(num_i) >= (W'(den_i) << QUO_W);
  assign rem_d[0] = W'(num_i);
  assign quo_d[0] = '0;

  for (genvar j = 1; j <= QUO_W; j++) begin : g_step
    logic [W-1:0] trial;
    logic         ge;
    assign trial = W'(den_q[j-1]) << (QUO_W - j);
    assign ge = rem_q[j-1] >= trial;
    assign rem_d[j] = ge ? rem_q[j-1] - trial : rem_q[j-1];
    always_comb begin
      quo_d[j] = quo_q[j-1];
      quo_d[j][QUO_W-j] = ge;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j <= QUO_W; j++) begin
      if (en_i[j]) begin
        rem_q[j] <= rem_d[j];
        quo_q[j] <= quo_d[j];
        den_q[j] <= (j == 0) ? den_i : den_q[(j == 0) ? 0 : j - 1];
        ovf_q[j] <= (j == 0) ? ovf_d : ovf_q[(j == 0) ? 0 : j - 1];
      end
    end
  end

  assign quo_o = ovf_q[QUO_W] ? '1 : quo_q[QUO_W];

endmodule

// File: hw/rtl/gas_sensor_ppm_linearizer_core.sv
// Gas sensor linearizer: sample to mV, percent, resistance, ratio and power-law ppm.
// A 65-stage pipeline runs from request acceptance to result valid. Throughput: one
// request per cycle unless the result side stalls; a full stage holds while its successor
// holds. The long path is the 25-stage divider bank, followed by 16 log2 squaring stages
// and 16 exp2 multiply stages. Reset clears valid bits and loads register defaults.
`include "assert_macros.svh"

module gas_sensor_ppm_linearizer_core #(
  parameter int ADC_BITS = 12,
  parameter int RATIO_FRAC_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_idx_i,
  input  logic [19:0]       cfg_data_i,
  gspl_in_if.sink           in_i,
  gspl_out_if.source        out_o
);

  localparam int SW = gspl_pkg::SAMPLE_W;
  localparam int QW = gspl_pkg::QUO_W;
  localparam int MASK_BITS = (ADC_BITS < SW) ? ADC_BITS : SW;
  localparam logic [SW-1:0] S_MASK = SW'((1 << MASK_BITS) - 1);

  localparam int ST_MUL  = 1;
  localparam int ST_DIV0 = ST_MUL + 1;
  localparam int ST_DIVN = ST_DIV0 + QW;
  localparam int ST_SAT  = ST_DIVN + 1;
  localparam int ST_NORM = ST_SAT + 1;
  localparam int ST_LOG0 = ST_NORM + 1;
  localparam int ST_G    = ST_LOG0 + gspl_pkg::LOG_STEPS;
  localparam int ST_REC  = ST_G + 1;
  localparam int ST_CORR = ST_REC + 1;
  localparam int ST_EXP0 = ST_CORR + 1;
  localparam int ST_OUT  = ST_EXP0 + gspl_pkg::EXP_STEPS;
  localparam int NS      = ST_OUT + 1;

  localparam int NR_W = RATIO_FRAC_BITS + 38;

  // g + 2000*2^16 = K_G - 1497*log2(ratio_q16), all in Q16 units of 1/1000.
  localparam logic [32:0] K_G = 33'(1000 * gspl_pkg::C_Q16 + 64'd8000 * 65536
                                    + 64'd1497 * 65536 * longint'(RATIO_FRAC_BITS));
  localparam logic [32:0] G_ZERO = 33'(64'd1000 * 65536);

  logic [15:0] fs_q;
  logic [12:0] supply_q;
  logic [19:0] load_q;
  logic [19:0] clean_q;
  logic [15:0] fs_eff;

  gspl_pkg::pipe_t st_q [NS];
  gspl_pkg::pipe_t st_d [NS];
  logic [NS-1:0]   vld_q;
  logic [NS-1:0]   vin;
  logic [NS:0]     en;

  logic [QW-1:0] q_mv, q_pct, q_rs, q_ra;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fs_q     <= 16'd4095;
      supply_q <= 13'd3300;
      load_q   <= 20'd10000;
      clean_q  <= 20'd10000;
    end else if (cfg_we_i) begin
      unique case (gspl_pkg::cfg_idx_e'(cfg_idx_i))
        gspl_pkg::CFG_ADC_FULL_SCALE: fs_q     <= cfg_data_i[15:0];
        gspl_pkg::CFG_SUPPLY_MV:      supply_q <= cfg_data_i[12:0];
        gspl_pkg::CFG_LOAD_OHMS:      load_q   <= cfg_data_i;
        gspl_pkg::CFG_CLEAN_AIR_OHMS: clean_q  <= cfg_data_i;
      endcase
    end
  end

  assign fs_eff = (fs_q == '0) ? 16'd1 : fs_q;

  // Stage handshake: a stage loads when it is empty or its successor moves on.
  assign en[NS] = out_o.ready;
  for (genvar k = 0; k < NS; k++) begin : g_en
    assign en[k] = !vld_q[k] || en[k+1];
  end
  assign vin = {vld_q[NS-2:0], in_i.valid};
  assign in_i.ready = en[0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      for (int k = 0; k < NS; k++) begin
        if (en[k]) vld_q[k] <= vin[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < NS; k++) begin
      if (en[k]) st_q[k] <= st_d[k];
    end
  end

  always_comb begin
    st_d[0] = '0;
    st_d[0].s = in_i.adc_sample & S_MASK;
    st_d[0].alert = in_i.alert_in;
  end

  // Divider bank, all four quotients in lockstep with stages ST_DIV0..ST_DIVN.
  gspl_div #(.NUM_W(27), .DEN_W(17), .QUO_W(QW)) u_div_mv (
    .clk_i (clk_i),
    .en_i  (en[ST_DIV0 +: QW+1]),
    .num_i ({st_q[ST_MUL].sv, 1'b0} + 27'(fs_eff)),
    .den_i ({fs_eff, 1'b0}),
    .quo_o (q_mv)
  );

  gspl_div #(.NUM_W(21), .DEN_W(17), .QUO_W(QW)) u_div_pct (
    .clk_i (clk_i),
    .en_i  (en[ST_DIV0 +: QW+1]),
    .num_i (21'(st_q[ST_MUL].s) * 21'd200 + 21'(fs_eff)),
    .den_i ({fs_eff, 1'b0}),
    .quo_o (q_pct)
  );

  gspl_div #(.NUM_W(38), .DEN_W(13), .QUO_W(QW)) u_div_rs (
    .clk_i (clk_i),
    .en_i  (en[ST_DIV0 +: QW+1]),
    .num_i ({1'b0, st_q[ST_MUL].num, 1'b0} + 38'(st_q[ST_MUL].s)),
    .den_i ({st_q[ST_MUL].s, 1'b0}),
    .quo_o (q_rs)
  );

  gspl_div #(.NUM_W(NR_W), .DEN_W(33), .QUO_W(QW)) u_div_ratio (
    .clk_i (clk_i),
    .en_i  (en[ST_DIV0 +: QW+1]),
    .num_i ((NR_W'(st_q[ST_MUL].num) << (RATIO_FRAC_BITS + 1)) + NR_W'(st_q[ST_MUL].den)),
    .den_i ({st_q[ST_MUL].den, 1'b0}),
    .quo_o (q_ra)
  );

  for (genvar k = 1; k < NS; k++) begin : g_stage
    if (k == ST_MUL) begin : g_mul
      always_comb begin
        logic [24:0] sv;
        sv = 25'(st_q[k-1].s) * 25'(supply_q);
        st_d[k] = st_q[k-1];
        st_d[k].sv = sv;
        st_d[k].num = 36'(load_q) * 36'(fs_eff - 16'(st_q[k-1].s));
        st_d[k].den = 32'(st_q[k-1].s) * 32'(clean_q);
        // Resistance, ratio and ppm stay zero at or below 10 mV and at or above full scale.
        st_d[k].calc = (sv > 25'(fs_eff) * 25'(gspl_pkg::LOW_MV_LIM))
                       && (16'(st_q[k-1].s) < fs_eff);
        st_d[k].cz = (clean_q == '0);
      end
    end else if (k == ST_SAT) begin : g_sat
      always_comb begin
        st_d[k] = st_q[k-1];
        st_d[k].mv = (q_mv > QW'(gspl_pkg::MV_MAX)) ? gspl_pkg::MV_MAX : q_mv[12:0];
        st_d[k].pct = (q_pct > QW'(gspl_pkg::PCT_MAX)) ? gspl_pkg::PCT_MAX : q_pct[6:0];
        st_d[k].rs = st_q[k-1].calc ? q_rs : '0;
        if (!st_q[k-1].calc) st_d[k].ratio = '0;
        else if (st_q[k-1].cz) st_d[k].ratio = gspl_pkg::SAT24;
        else st_d[k].ratio = q_ra;
      end
    end else if (k == ST_NORM) begin : g_norm
      always_comb begin
        logic [4:0] msb;
        msb = '0;
        for (int i = 0; i < 24; i++) begin
          if (st_q[k-1].ratio[i]) msb = 5'(i);
        end
        st_d[k] = st_q[k-1];
        st_d[k].msb = msb;
        st_d[k].mant = 31'(st_q[k-1].ratio) << (5'd30 - msb);
        st_d[k].frac = '0;
        st_d[k].pz = (st_q[k-1].ratio == '0);
      end
    end else if (k >= ST_LOG0 && k < ST_G) begin : g_log
      always_comb begin
        logic [61:0] sq;
        sq = 62'(st_q[k-1].mant) * 62'(st_q[k-1].mant);
        st_d[k] = st_q[k-1];
        if (sq[61]) begin
          st_d[k].mant = sq[61:31];
          st_d[k].frac[15 - (k - ST_LOG0)] = 1'b1;
        end else begin
          st_d[k].mant = sq[60:30];
        end
      end
    end else if (k == ST_G) begin : g_g
      always_comb begin
        logic [32:0] p;
        p = 33'({st_q[k-1].msb, st_q[k-1].frac}) * 33'd1497;
        st_d[k] = st_q[k-1];
        st_d[k].gp = 32'(K_G - p);
        if (p + G_ZERO > K_G) st_d[k].pz = 1'b1;
      end
    end else if (k == ST_REC) begin : g_rec
      always_comb begin
        logic [63:0] prod;
        prod = 64'(st_q[k-1].gp) * 64'(gspl_pkg::RECIP_1000);
        st_d[k] = st_q[k-1];
        st_d[k].q0 = prod[63:41];
      end
    end else if (k == ST_CORR) begin : g_corr
      always_comb begin
        logic [32:0] r;
        logic [22:0] h;
        // The reciprocal estimate is low by at most one.
        r = 33'(st_q[k-1].gp) - 33'(st_q[k-1].q0) * 33'd1000;
        h = st_q[k-1].q0 + 23'(r >= 33'd1000);
        st_d[k] = st_q[k-1];
        st_d[k].ip = h[22:16];
        st_d[k].ef = h[15:0];
        st_d[k].psat = (h[22:16] >= 7'(gspl_pkg::PPM_IP_MAX));
        st_d[k].ex = 31'(1) << 30;
      end
    end else if (k >= ST_EXP0 && k < ST_OUT) begin : g_exp
      localparam int B = 15 - (k - ST_EXP0);
      localparam logic [30:0] ROOT = gspl_pkg::exp_root(B);
      always_comb begin
        logic [61:0] prod;
        prod = 62'(st_q[k-1].ex) * 62'(ROOT);
        st_d[k] = st_q[k-1];
        if (st_q[k-1].ef[B]) st_d[k].ex = prod[60:30];
      end
    end else if (k == ST_OUT) begin : g_out
      always_comb begin
        logic [48:0] sh;
        logic [16:0] v;
        sh = (49'(st_q[k-1].ex) << st_q[k-1].ip) + (49'(1) << 31);
        v = sh[48:32];
        st_d[k] = st_q[k-1];
        if (st_q[k-1].pz) st_d[k].ppm = '0;
        else if (st_q[k-1].psat) st_d[k].ppm = gspl_pkg::PPM_MAX_Q6;
        else if (v > 17'(gspl_pkg::PPM_MAX_Q6)) st_d[k].ppm = gspl_pkg::PPM_MAX_Q6;
        else st_d[k].ppm = v[15:0];
      end
    end else begin : g_pass
      assign st_d[k] = st_q[k-1];
    end
  end

  assign out_o.valid       = vld_q[ST_OUT];
  assign out_o.voltage_mv  = st_q[ST_OUT].mv;
  assign out_o.percent     = st_q[ST_OUT].pct;
  assign out_o.sensor_ohms = st_q[ST_OUT].rs;
  assign out_o.ratio_q16   = st_q[ST_OUT].ratio;
  assign out_o.ppm_q6      = st_q[ST_OUT].ppm;
  assign out_o.alert_out   = st_q[ST_OUT].alert;

  `GSPL_ASSERT(a_zero_ratio_zero_ppm, out_o.valid && out_o.ratio_q16 == '0 |-> out_o.ppm_q6 == '0)
  `GSPL_ASSERT(a_ppm_clamped, out_o.valid |-> out_o.ppm_q6 <= gspl_pkg::PPM_MAX_Q6)
  `GSPL_ASSERT_MSG(a_out_from_pipe, $rose(vld_q[ST_OUT]) |-> $past(vld_q[ST_OUT-1]), "result without upstream request")

endmodule

// File: tb/gas_sensor_ppm_linearizer_checker.sv
// Watches the linearizer channels, predicts each result and compares it field by field.
module gas_sensor_ppm_linearizer_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [19:0] cfg_data_i,
  gspl_in_if          in_if,
  gspl_out_if         out_if,
  output int          errors_o,
  output int          pending_o,
  output int          requests_o,
  output int          results_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS = 16;

  typedef struct packed {
    logic [12:0] mv;
    logic [6:0]  pct;
    logic [23:0] ohms;
    logic [23:0] ratio;
    logic [15:0] ppm;
    logic        alert;
  } reading_t;

  reading_t        expected_readings[$];
  logic [15:0]     full_scale;
  logic [12:0]     supply;
  logic [19:0]     load_r;
  logic [19:0]     clean_r;
  longint unsigned half_roots[16];

  assign pending_o = expected_readings.size();

  function automatic longint unsigned floor_sqrt(input longint unsigned v);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= v) r = t;
    end
    return r;
  endfunction

  // Integer part from the leading one, fraction by repeated squaring of the mantissa.
  function automatic longint unsigned log2_fixed(input longint unsigned x);
    int              top;
    longint unsigned m;
    longint unsigned f;
    top = 0;
    f = 0;
    for (int b = 29; b >= 0; b--) begin
      if (x[b] && top == 0) top = b;
    end
    m = x << (30 - top);
    for (int i = 15; i >= 0; i--) begin
      m = (m * m) >> 30;
      if (m >= (64'd1 << 31)) begin
        m = m >> 1;
        f[i] = 1'b1;
      end
    end
    return (longint'(top) << 16) | f;
  endfunction

  function automatic logic [15:0] ppm_of_ratio(input longint unsigned ratio);
    longint          lg;
    longint          c;
    longint          g;
    longint unsigned h;
    longint unsigned ip;
    longint unsigned m;
    if (ratio == 0) return 16'd0;
    c = longint'((152 * log2_fixed(10) + 50) / 100);
    lg = longint'(log2_fixed(ratio)) - longint'(FRAC_BITS) * 65536;
    g = 1000 * c - 1497 * lg + longint'(6000) * 65536;
    if (g < -longint'(1000) * 65536) return 16'd0;
    h = longint'(g + longint'(2000) * 65536) / 1000;
    ip = h >> 16;
    if (ip >= 18) return 16'd64000;
    m = 64'd1 << 30;
    for (int k = 15; k >= 0; k--) begin
      if (h[k]) m = (m * half_roots[k]) >> 30;
    end
    m = ((m << ip) + (64'd1 << 31)) >> 32;
    return (m > 64000) ? 16'd64000 : m[15:0];
  endfunction

  function automatic reading_t linearize(input logic [11:0] sample, input logic alert);
    reading_t        rd;
    longint unsigned s;
    longint unsigned fs;
    longint unsigned v;
    longint unsigned num;
    longint unsigned den;
    longint unsigned t;
    s = sample;
    fs = (full_scale == 0) ? 1 : full_scale;
    v = supply;
    rd = '0;
    rd.alert = alert;
    t = (2 * s * v + fs) / (2 * fs);
    rd.mv = (t > 8191) ? 13'd8191 : t[12:0];
    t = (200 * s + fs) / (2 * fs);
    rd.pct = (t > 127) ? 7'd127 : t[6:0];
    if (s * v > 10 * fs && s < fs) begin
      num = longint'(load_r) * (fs - s);
      t = (2 * num + s) / (2 * s);
      rd.ohms = (t > 24'hFFFFFF) ? 24'hFFFFFF : t[23:0];
      if (clean_r == 0) begin
        rd.ratio = 24'hFFFFFF;
      end else begin
        den = s * clean_r;
        t = ((num << FRAC_BITS) * 2 + den) / (2 * den);
        rd.ratio = (t > 24'hFFFFFF) ? 24'hFFFFFF : t[23:0];
      end
      rd.ppm = ppm_of_ratio(rd.ratio);
    end
    return rd;
  endfunction

  task automatic report(input string field, input longint unsigned want,
                        input longint unsigned got);
    errors_o++;
    $display("mismatch on %s: expected %0d, got %0d (result %0d)", field, want, got,
             results_o);
  endtask

  initial begin
    longint unsigned root;
    errors_o = 0;
    requests_o = 0;
    results_o = 0;
    root = 64'd2 << 30;
    for (int k = 15; k >= 0; k--) begin
      root = floor_sqrt(root << 30);
      half_roots[k] = root;
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    reading_t want;
    if (!rst_ni) begin
      full_scale <= 16'd4095;
      supply <= 13'd3300;
      load_r <= 20'd10000;
      clean_r <= 20'd10000;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_readings.push_back(linearize(in_if.adc_sample, in_if.alert_in));
        requests_o++;
      end
      if (out_if.valid && out_if.ready) begin
        results_o++;
        if (expected_readings.size() == 0) begin
          report("unexpected result", 0, 1);
        end else begin
          want = expected_readings.pop_front();
          if (want.mv !== out_if.voltage_mv) report("voltage_mv", want.mv, out_if.voltage_mv);
          if (want.pct !== out_if.percent) report("percent", want.pct, out_if.percent);
          if (want.ohms !== out_if.sensor_ohms)
            report("sensor_ohms", want.ohms, out_if.sensor_ohms);
          if (want.ratio !== out_if.ratio_q16) report("ratio_q16", want.ratio, out_if.ratio_q16);
          if (want.ppm !== out_if.ppm_q6) report("ppm_q6", want.ppm, out_if.ppm_q6);
          if (want.alert !== out_if.alert_out) report("alert_out", want.alert, out_if.alert_out);
        end
      end
      if (cfg_we_i) begin
        case (gspl_pkg::cfg_idx_e'(cfg_idx_i))
          gspl_pkg::CFG_ADC_FULL_SCALE: full_scale <= cfg_data_i[15:0];
          gspl_pkg::CFG_SUPPLY_MV:      supply <= cfg_data_i[12:0];
          gspl_pkg::CFG_LOAD_OHMS:      load_r <= cfg_data_i;
          gspl_pkg::CFG_CLEAN_AIR_OHMS: clean_r <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end
endmodule

// File: tb/gas_sensor_ppm_linearizer_core_test.sv
// Top of the linearizer testbench: clock, reset, configuration phases and request traffic.
module gas_sensor_ppm_linearizer_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;
  localparam int PHASES = 8;
  localparam int PHASE_REQUESTS = 232;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_idx_i = gspl_pkg::CFG_ADC_FULL_SCALE;
  logic [19:0] cfg_data_i = '0;
  logic        calm = 1'b0;
  int          stall_left = 0;
  int          cycles = 0;
  int          errors;
  int          pending;
  int          requests;
  int          results;

  gspl_in_if  in_ch();
  gspl_out_if out_ch();

  initial begin
    in_ch.valid = 1'b0;
    in_ch.adc_sample = '0;
    in_ch.alert_in = 1'b0;
    out_ch.ready = 1'b0;
  end

  gas_sensor_ppm_linearizer_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .in_i(in_ch), .out_o(out_ch)
  );

  gas_sensor_ppm_linearizer_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .in_if(in_ch), .out_if(out_ch),
    .errors_o(errors), .pending_o(pending), .requests_o(requests), .results_o(results)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles with %0d results outstanding", cycles, pending);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // The result side stalls in random bursts until the calm last phase.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 9);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  task automatic send(input logic [11:0] sample, input logic alert);
    if (!calm && $urandom_range(0, 9) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.adc_sample <= sample;
    in_ch.alert_in <= alert;
    do @(posedge clk_i); while (!in_ch.ready);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input gspl_pkg::cfg_idx_e idx, input logic [19:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  initial begin
    logic [19:0] setting[PHASES][4];
    logic [11:0] s;
    setting[0] = '{20'd4095, 20'd5500, 20'd1000000, 20'd100};
    setting[1] = '{20'd4095, 20'd1000, 20'd100, 20'd1000000};
    setting[2] = '{20'd1, 20'd3300, 20'd10000, 20'd10000};
    setting[3] = '{20'd65535, 20'd5500, 20'd1000000, 20'd1000000};
    setting[4] = '{20'd0, 20'd0, 20'd100, 20'd0};
    setting[5] = '{20'd3000, 20'd8191, 20'hFFFFF, 20'hFFFFF};
    setting[6] = '{20'd2048, 20'd3300, 20'd22000, 20'd3000};
    setting[7] = '{20'd4095, 20'd3300, 20'd10000, 20'd10000};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset settings: range ends, the low-voltage edge near 10 mV, full scale, alert levels.
    send(12'd0, 1'b0);
    send(12'd1, 1'b1);
    send(12'd12, 1'b0);
    send(12'd13, 1'b1);
    send(12'd4095, 1'b1);
    send(12'd4094, 1'b0);
    send(12'd2048, 1'b1);
    send(12'hAAA, 1'b0);
    send(12'h555, 1'b1);
    send(12'd40, 1'b0);
    send(12'd1000, 1'b1);
    send(12'd3900, 1'b0);

    for (int p = 0; p < PHASES; p++) begin
      settle();
      write_reg(gspl_pkg::CFG_ADC_FULL_SCALE, setting[p][0]);
      write_reg(gspl_pkg::CFG_SUPPLY_MV, setting[p][1]);
      write_reg(gspl_pkg::CFG_LOAD_OHMS, setting[p][2]);
      write_reg(gspl_pkg::CFG_CLEAN_AIR_OHMS, setting[p][3]);
      cfg_we_i <= 1'b0;
      calm <= (p == PHASES - 1);
      for (int n = 0; n < PHASE_REQUESTS; n++) begin
        // A quarter of the samples sit low, where resistance and ratio grow large.
        s = ($urandom_range(0, 3) == 0) ? 12'($urandom_range(0, 64)) : 12'($urandom);
        send(s, 1'($urandom));
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d requests and %0d results checked across %0d register settings",
             requests, results, PHASES + 1);
    $display("settings included zero and maximum full scale, supply and resistances");
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
